@@ hdl/bctx_pkg.sv @@
// Shared types and constants for the transaction stream parser.
`timescale 1ns / 1ps

package bctx_pkg;

    // Width of entry counts, script lengths and witness counters.
    localparam int COUNT_WIDTH = 32;
    localparam logic [63:0] COUNT_MASK = 64'((65'd1 << COUNT_WIDTH) - 65'd1);

    // Segwit marker and flag bytes that follow the version.
    localparam logic [7:0] SEGWIT_MARKER = 8'h00;
    localparam logic [7:0] SEGWIT_FLAG   = 8'h01;

    typedef enum logic [3:0] {
        KIND_VERSION    = 4'd0,
        KIND_SEGWIT     = 4'd1,
        KIND_IN_COUNT   = 4'd2,
        KIND_HASH_BYTE  = 4'd3,
        KIND_PREV_INDEX = 4'd4,
        KIND_IN_LEN     = 4'd5,
        KIND_IN_BYTE    = 4'd6,
        KIND_SEQUENCE   = 4'd7,
        KIND_OUT_COUNT  = 4'd8,
        KIND_VALUE      = 4'd9,
        KIND_OUT_LEN    = 4'd10,
        KIND_OUT_BYTE   = 4'd11,
        KIND_LOCKTIME   = 4'd12,
        KIND_OK         = 4'd13,
        KIND_PARSE_ERR  = 4'd14,
        KIND_TOO_LARGE  = 4'd15
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] value;
        logic [31:0] entry;
        logic        coinbase;
        logic        last;
    } rec_t;

    // Records produced by one byte: count in n, first in r0, second in r1.
    typedef struct packed {
        rec_t       r0;
        rec_t       r1;
        logic [1:0] n;
    } rec_pair_t;

endpackage

@@ hdl/bitcoin_tx_stream_parser.sv @@
// Top level of the byte-serial transaction parser: input register and result slots.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one byte of a serialized
//   transaction per item, with final_byte set on the buffer's last byte.
//   Output channel (out_valid / out_stall) carries one record per item:
//   field_kind, field_value, entry_number, is_coinbase, end_of_transaction.
// Path: an accepted byte waits in the input register; decoding it registers its records.
// Throughput: one byte per cycle while each byte yields zero or one record and
//   out_stall is low. A byte that yields two records (locktime plus ok, a held
//   zero followed by an output count, or any record plus a parse error) holds the
//   next byte back, because the result slots drain one record per cycle.
// Storage: one input register, then a presented result slot and a spare slot.
//   A byte is decoded only when the spare slot is empty and the presented slot
//   is empty or being taken, so both of its records always fit.
// Stall: with out_stall high the presented record holds; the next byte then
//   waits in the input register and in_stall rises until the record is taken.
// Reset: drops all items in flight and returns the parser to expect the
//   version field. Every final byte also returns it to that state.
module bitcoin_tx_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  field_kind,
    output logic [63:0] field_value,
    output logic [31:0] entry_number,
    output logic        is_coinbase,
    output logic        end_of_transaction
);
    import bctx_pkg::*;

    // Input register.
    logic        in_full_reg;
    logic [7:0]  byte_reg;
    logic        fin_reg;

    // Result slots: A is presented on the ports, B holds a second record.
    logic        a_full_reg;
    logic        b_full_reg;
    rec_t        a_reg;
    rec_t        b_reg;

    logic        in_fire;
    logic        out_fire;
    logic        step;
    rec_pair_t   recs;

    assign out_fire = a_full_reg && !out_stall;
    // Decode when both records of this byte are sure to fit.
    assign step     = in_full_reg && !b_full_reg && (!a_full_reg || out_fire);
    assign in_stall = in_full_reg && !step;
    assign in_fire  = in_valid && !in_stall;

    bctx_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (byte_reg),
        .final_byte (fin_reg),
        .recs       (recs)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            a_full_reg  <= 1'b0;
            b_full_reg  <= 1'b0;
        end
        else
        begin
            // Hold the byte until it is decoded; load the next one behind it.
            if (in_fire)
            begin
                in_full_reg <= 1'b1;
            end
            else if (step)
            begin
                in_full_reg <= 1'b0;
            end

            if (step)
            begin
                a_full_reg <= (recs.n != 2'd0);
                b_full_reg <= (recs.n == 2'd2);
            end
            else if (out_fire)
            begin
                // Advance the spare record into the presented slot.
                a_full_reg <= b_full_reg;
                b_full_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= data_byte;
            fin_reg  <= final_byte;
        end
        if (step)
        begin
            a_reg <= recs.r0;
            b_reg <= recs.r1;
        end
        else if (out_fire)
        begin
            a_reg <= b_reg;
        end
    end

    assign out_valid          = a_full_reg;
    assign field_kind         = a_reg.kind;
    assign field_value        = a_reg.value;
    assign entry_number       = a_reg.entry;
    assign is_coinbase        = a_reg.coinbase;
    assign end_of_transaction = a_reg.last;

endmodule

@@ hdl/bctx_core.sv @@
// Parse state registers and per-byte decode into at most two records.
`timescale 1ns / 1ps

module bctx_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output bctx_pkg::rec_pair_t recs
);
    import bctx_pkg::*;

    localparam logic [7:0] CS_16 = 8'hfd;
    localparam logic [7:0] CS_32 = 8'hfe;

    typedef enum logic [4:0] {
        PH_VERSION, PH_MARK, PH_FLAG, PH_INCOUNT, PH_HASH, PH_INDEX, PH_INLEN,
        PH_INSCRIPT, PH_SEQ, PH_OUTCOUNT, PH_VALUE, PH_OUTLEN, PH_OUTSCRIPT,
        PH_WITCOUNT, PH_WITLEN, PH_WITDATA, PH_LOCK, PH_DONE
    } phase_t;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  vlen_reg, vlen_next;
    logic [63:0] acc_reg, acc_next;
    cnt_t        in_left_reg, in_left_next;
    cnt_t        out_left_reg, out_left_next;
    cnt_t        bytes_reg, bytes_next;
    cnt_t        wit_reg, wit_next;
    cnt_t        ent_reg, ent_next;
    logic        seg_reg, seg_next;
    logic        hz_reg, hz_next;

    // Shared byte accumulator, CompactSize and fixed-field helpers.
    logic [63:0] acc_ins;
    logic [3:0]  pos_inc;
    logic        var_first, var_done, var_big;
    logic [63:0] var_val;
    logic [3:0]  var_pos, var_vlen;
    logic [63:0] var_acc;
    logic        fx4_done, fx8_done;
    cnt_t        var_cnt;
    logic        idx_cb;
    rec_pair_t   p;

    function automatic rec_t mk_rec(kind_t k, logic [63:0] v, cnt_t e, logic cb, logic last);
        rec_t r;
        r.kind     = k;
        r.value    = v;
        r.entry    = 32'(e);
        r.coinbase = cb;
        r.last     = last;
        return r;
    endfunction

    // Append a record; a third one replaces the second.
    function automatic rec_pair_t push_rec(rec_pair_t q, rec_t r);
        rec_pair_t o;
        o = q;
        if (q.n == 2'd0)
        begin
            o.r0 = r;
            o.n  = 2'd1;
        end
        else
        begin
            o.r1 = r;
            o.n  = 2'd2;
        end
        return o;
    endfunction

    always_comb
    begin
        acc_ins   = acc_reg | (64'(data_byte) << {pos_reg[2:0], 3'b000});
        pos_inc   = pos_reg + 4'd1;
        var_first = (vlen_reg == 4'd0);
        var_done  = var_first ? (data_byte < CS_16) : (pos_inc >= vlen_reg);
        var_val   = var_first ? 64'(data_byte) : acc_ins;
        var_big   = (var_val > COUNT_MASK);
        var_cnt   = cnt_t'(var_val);
        fx4_done  = (pos_inc >= 4'd4);
        fx8_done  = (pos_inc >= 4'd8);
        idx_cb    = hz_reg && (acc_ins == 64'h0000_0000_ffff_ffff);

        var_pos  = pos_reg;
        var_vlen = vlen_reg;
        var_acc  = acc_reg;
        if (var_first)
        begin
            if (!var_done)
            begin
                var_vlen = (data_byte == CS_16) ? 4'd2 : (data_byte == CS_32) ? 4'd4 : 4'd8;
                var_pos  = 4'd0;
                var_acc  = '0;
            end
        end
        else if (var_done)
        begin
            var_pos  = 4'd0;
            var_vlen = 4'd0;
            var_acc  = '0;
        end
        else
        begin
            var_pos = pos_inc;
            var_acc = acc_ins;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        vlen_next     = vlen_reg;
        acc_next      = acc_reg;
        in_left_next  = in_left_reg;
        out_left_next = out_left_reg;
        bytes_next    = bytes_reg;
        wit_next      = wit_reg;
        ent_next      = ent_reg;
        seg_next      = seg_reg;
        hz_next       = hz_reg;
        p             = '0;

        unique case (phase_reg)
            PH_VERSION:
            begin
                pos_next = fx4_done ? 4'd0 : pos_inc;
                acc_next = fx4_done ? 64'd0 : acc_ins;
                if (fx4_done)
                begin
                    p = push_rec(p, mk_rec(KIND_VERSION, acc_ins, '0, 1'b0, 1'b0));
                    phase_next = PH_MARK;
                end
            end
            PH_MARK, PH_INCOUNT:
            begin
                if (phase_reg == PH_MARK && data_byte == SEGWIT_MARKER && !final_byte)
                begin
                    phase_next = PH_FLAG;
                end
                else
                begin
                    phase_next = PH_INCOUNT;
                    pos_next   = var_pos;
                    vlen_next  = var_vlen;
                    acc_next   = var_acc;
                    if (var_done && var_big)
                    begin
                        p = push_rec(p, mk_rec(KIND_TOO_LARGE, var_val, '0, 1'b0, 1'b1));
                        phase_next = PH_DONE;
                    end
                    else if (var_done)
                    begin
                        p = push_rec(p, mk_rec(KIND_IN_COUNT, var_val, '0, 1'b0, 1'b0));
                        ent_next = '0;
                        if (var_val == 64'd0)
                        begin
                            in_left_next = '0;
                            phase_next   = PH_OUTCOUNT;
                        end
                        else
                        begin
                            in_left_next = var_cnt;
                            hz_next      = 1'b1;
                            bytes_next   = cnt_t'(32);
                            phase_next   = PH_HASH;
                        end
                    end
                end
            end
            PH_FLAG:
            begin
                if (data_byte == SEGWIT_FLAG)
                begin
                    seg_next   = 1'b1;
                    p = push_rec(p, mk_rec(KIND_SEGWIT, 64'd1, '0, 1'b0, 1'b0));
                    phase_next = PH_INCOUNT;
                end
                else
                begin
                    // Held zero is an input count of zero; this byte is the output count.
                    p = push_rec(p, mk_rec(KIND_IN_COUNT, 64'd0, '0, 1'b0, 1'b0));
                    ent_next     = '0;
                    in_left_next = '0;
                    phase_next   = PH_OUTCOUNT;
                    pos_next     = var_pos;
                    vlen_next    = var_vlen;
                    acc_next     = var_acc;
                    if (var_done && var_big)
                    begin
                        p = push_rec(p, mk_rec(KIND_TOO_LARGE, var_val, '0, 1'b0, 1'b1));
                        phase_next = PH_DONE;
                    end
                    else if (var_done)
                    begin
                        p = push_rec(p, mk_rec(KIND_OUT_COUNT, var_val, '0, 1'b0, 1'b0));
                        out_left_next = var_cnt;
                        phase_next    = (var_val == 64'd0) ? PH_LOCK : PH_VALUE;
                    end
                end
            end
            PH_HASH:
            begin
                p = push_rec(p, mk_rec(KIND_HASH_BYTE, 64'(data_byte), ent_reg, 1'b0, 1'b0));
                if (data_byte != 8'd0)
                begin
                    hz_next = 1'b0;
                end
                bytes_next = bytes_reg - cnt_t'(1);
                if (bytes_reg == cnt_t'(1))
                begin
                    phase_next = PH_INDEX;
                end
            end
            PH_INDEX:
            begin
                pos_next = fx4_done ? 4'd0 : pos_inc;
                acc_next = fx4_done ? 64'd0 : acc_ins;
                if (fx4_done)
                begin
                    hz_next = idx_cb;
                    p = push_rec(p, mk_rec(KIND_PREV_INDEX, acc_ins, ent_reg, idx_cb, 1'b0));
                    phase_next = PH_INLEN;
                end
            end
            PH_INLEN:
            begin
                pos_next  = var_pos;
                vlen_next = var_vlen;
                acc_next  = var_acc;
                if (var_done && var_big)
                begin
                    p = push_rec(p, mk_rec(KIND_TOO_LARGE, var_val, '0, 1'b0, 1'b1));
                    phase_next = PH_DONE;
                end
                else if (var_done)
                begin
                    p = push_rec(p, mk_rec(KIND_IN_LEN, var_val, ent_reg, hz_reg, 1'b0));
                    bytes_next = var_cnt;
                    phase_next = (var_val == 64'd0) ? PH_SEQ : PH_INSCRIPT;
                end
            end
            PH_INSCRIPT:
            begin
                p = push_rec(p, mk_rec(KIND_IN_BYTE, 64'(data_byte), ent_reg, hz_reg, 1'b0));
                bytes_next = bytes_reg - cnt_t'(1);
                if (bytes_reg == cnt_t'(1))
                begin
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                pos_next = fx4_done ? 4'd0 : pos_inc;
                acc_next = fx4_done ? 64'd0 : acc_ins;
                if (fx4_done)
                begin
                    p = push_rec(p, mk_rec(KIND_SEQUENCE, acc_ins, ent_reg, hz_reg, 1'b0));
                    if (in_left_reg == cnt_t'(1))
                    begin
                        in_left_next = ent_reg + cnt_t'(1);
                        ent_next     = '0;
                        phase_next   = PH_OUTCOUNT;
                    end
                    else
                    begin
                        in_left_next = in_left_reg - cnt_t'(1);
                        ent_next     = ent_reg + cnt_t'(1);
                        hz_next      = 1'b1;
                        bytes_next   = cnt_t'(32);
                        phase_next   = PH_HASH;
                    end
                end
            end
            PH_OUTCOUNT:
            begin
                pos_next  = var_pos;
                vlen_next = var_vlen;
                acc_next  = var_acc;
                if (var_done && var_big)
                begin
                    p = push_rec(p, mk_rec(KIND_TOO_LARGE, var_val, '0, 1'b0, 1'b1));
                    phase_next = PH_DONE;
                end
                else if (var_done)
                begin
                    p = push_rec(p, mk_rec(KIND_OUT_COUNT, var_val, '0, 1'b0, 1'b0));
                    out_left_next = var_cnt;
                    if (var_val == 64'd0)
                    begin
                        ent_next   = '0;
                        phase_next = (seg_reg && in_left_reg != '0) ? PH_WITCOUNT : PH_LOCK;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                pos_next = fx8_done ? 4'd0 : pos_inc;
                acc_next = fx8_done ? 64'd0 : acc_ins;
                if (fx8_done)
                begin
                    p = push_rec(p, mk_rec(KIND_VALUE, acc_ins, ent_reg, 1'b0, 1'b0));
                    phase_next = PH_OUTLEN;
                end
            end
            PH_OUTLEN, PH_OUTSCRIPT:
            begin
                if (phase_reg == PH_OUTLEN)
                begin
                    pos_next  = var_pos;
                    vlen_next = var_vlen;
                    acc_next  = var_acc;
                end
                if (phase_reg == PH_OUTLEN && var_done && var_big)
                begin
                    p = push_rec(p, mk_rec(KIND_TOO_LARGE, var_val, '0, 1'b0, 1'b1));
                    phase_next = PH_DONE;
                end
                else if ((phase_reg == PH_OUTLEN && var_done) || phase_reg == PH_OUTSCRIPT)
                begin
                    if (phase_reg == PH_OUTLEN)
                    begin
                        p = push_rec(p, mk_rec(KIND_OUT_LEN, var_val, ent_reg, 1'b0, 1'b0));
                        bytes_next = var_cnt;
                        phase_next = PH_OUTSCRIPT;
                    end
                    else
                    begin
                        p = push_rec(p, mk_rec(KIND_OUT_BYTE, 64'(data_byte), ent_reg,
                                               1'b0, 1'b0));
                        bytes_next = bytes_reg - cnt_t'(1);
                    end
                    // Finish the output once its script is exhausted.
                    if ((phase_reg == PH_OUTLEN && var_val == 64'd0) ||
                        (phase_reg == PH_OUTSCRIPT && bytes_reg == cnt_t'(1)))
                    begin
                        out_left_next = out_left_reg - cnt_t'(1);
                        if (out_left_reg == cnt_t'(1))
                        begin
                            ent_next   = '0;
                            phase_next = (seg_reg && in_left_reg != '0) ? PH_WITCOUNT
                                                                        : PH_LOCK;
                        end
                        else
                        begin
                            ent_next   = ent_reg + cnt_t'(1);
                            phase_next = PH_VALUE;
                        end
                    end
                end
            end
            PH_WITCOUNT, PH_WITLEN, PH_WITDATA:
            begin
                if (phase_reg != PH_WITDATA)
                begin
                    pos_next  = var_pos;
                    vlen_next = var_vlen;
                    acc_next  = var_acc;
                end
                if (phase_reg != PH_WITDATA && var_done && var_big)
                begin
                    p = push_rec(p, mk_rec(KIND_TOO_LARGE, var_val, '0, 1'b0, 1'b1));
                    phase_next = PH_DONE;
                end
                else if (phase_reg == PH_WITCOUNT)
                begin
                    if (var_done)
                    begin
                        wit_next   = var_cnt;
                        phase_next = PH_WITLEN;
                        if (var_val == 64'd0)
                        begin
                            ent_next     = ent_reg + cnt_t'(1);
                            in_left_next = in_left_reg - cnt_t'(1);
                            phase_next   = (in_left_reg == cnt_t'(1)) ? PH_LOCK : PH_WITCOUNT;
                        end
                    end
                end
                else if ((phase_reg == PH_WITLEN && var_done) || phase_reg == PH_WITDATA)
                begin
                    if (phase_reg == PH_WITLEN)
                    begin
                        bytes_next = var_cnt;
                        phase_next = PH_WITDATA;
                    end
                    else
                    begin
                        bytes_next = bytes_reg - cnt_t'(1);
                    end
                    // Item done: advance to next item or next input's stack.
                    if ((phase_reg == PH_WITLEN && var_val == 64'd0) ||
                        (phase_reg == PH_WITDATA && bytes_reg == cnt_t'(1)))
                    begin
                        wit_next   = wit_reg - cnt_t'(1);
                        phase_next = PH_WITLEN;
                        if (wit_reg == cnt_t'(1))
                        begin
                            ent_next     = ent_reg + cnt_t'(1);
                            in_left_next = in_left_reg - cnt_t'(1);
                            phase_next   = (in_left_reg == cnt_t'(1)) ? PH_LOCK : PH_WITCOUNT;
                        end
                    end
                end
            end
            PH_LOCK:
            begin
                pos_next = fx4_done ? 4'd0 : pos_inc;
                acc_next = fx4_done ? 64'd0 : acc_ins;
                if (fx4_done)
                begin
                    p = push_rec(p, mk_rec(KIND_LOCKTIME, acc_ins, '0, 1'b0, 1'b0));
                    p = push_rec(p, mk_rec(KIND_OK, 64'd0, '0, 1'b0, 1'b1));
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Last byte of the buffer: flag an early end, then return to reset state.
        if (final_byte)
        begin
            if (phase_next != PH_DONE)
            begin
                p = push_rec(p, mk_rec(KIND_PARSE_ERR, 64'd0, '0, 1'b0, 1'b1));
            end
            phase_next    = PH_VERSION;
            pos_next      = 4'd0;
            vlen_next     = 4'd0;
            acc_next      = '0;
            in_left_next  = '0;
            out_left_next = '0;
            bytes_next    = '0;
            wit_next      = '0;
            ent_next      = '0;
            seg_next      = 1'b0;
            hz_next       = 1'b1;
        end
    end

    assign recs = p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_VERSION;
            pos_reg      <= 4'd0;
            vlen_reg     <= 4'd0;
            acc_reg      <= '0;
            in_left_reg  <= '0;
            out_left_reg <= '0;
            bytes_reg    <= '0;
            wit_reg      <= '0;
            ent_reg      <= '0;
            seg_reg      <= 1'b0;
            hz_reg       <= 1'b1;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            vlen_reg     <= vlen_next;
            acc_reg      <= acc_next;
            in_left_reg  <= in_left_next;
            out_left_reg <= out_left_next;
            bytes_reg    <= bytes_next;
            wit_reg      <= wit_next;
            ent_reg      <= ent_next;
            seg_reg      <= seg_next;
            hz_reg       <= hz_next;
        end
    end

endmodule

@@ hdl/bctx_checker.sv @@
// Port-level checks on the parser's record stream, bound to the top level.
`timescale 1ns / 1ps

module bctx_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  data_byte,
    input logic        final_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  field_kind,
    input logic [63:0] field_value,
    input logic [31:0] entry_number,
    input logic        is_coinbase,
    input logic        end_of_transaction
);
    import bctx_pkg::*;

    // Only ok, parse error and count-too-large close a transaction.
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (end_of_transaction ==
            (field_kind == KIND_OK || field_kind == KIND_PARSE_ERR ||
             field_kind == KIND_TOO_LARGE)))
        else $error("end_of_transaction does not match a closing record");

    // Coinbase flag appears only on index, script length, script and sequence.
    a_coinbase_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_coinbase) |->
            (field_kind == KIND_PREV_INDEX || field_kind == KIND_IN_LEN ||
             field_kind == KIND_IN_BYTE || field_kind == KIND_SEQUENCE))
        else $error("is_coinbase set on a record outside an input");

    // Segwit record always carries value one, and closing records other than
    // count-too-large carry zero.
    a_fixed_values: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (field_kind == KIND_SEGWIT || field_kind == KIND_OK ||
                       field_kind == KIND_PARSE_ERR)) |->
            (field_value == ((field_kind == KIND_SEGWIT) ? 64'd1 : 64'd0) &&
             entry_number == 32'd0))
        else $error("fixed record carries an unexpected value");

    // A stalled record holds until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(field_kind) && $stable(field_value) &&
             $stable(entry_number) && $stable(end_of_transaction)))
        else $error("stalled record changed");

endmodule

bind bitcoin_tx_stream_parser bctx_checker u_bctx_checker (.*);

@@ sim/bctx_tb_pkg.sv @@
// Shadow parser and record checker used by the transaction parser testbench.
`timescale 1ns / 1ps

package bctx_tb_pkg;

    import bctx_pkg::*;

    // CompactSize prefixes for 2, 4 and 8 byte bodies.
    localparam logic [7:0] CS_PREFIX16 = 8'hfd;
    localparam logic [7:0] CS_PREFIX32 = 8'hfe;
    localparam logic [7:0] CS_PREFIX64 = 8'hff;

    typedef enum logic [4:0] {
        ST_VERSION, ST_MARK, ST_FLAG, ST_IN_COUNT, ST_HASH, ST_INDEX, ST_IN_LEN,
        ST_IN_SCRIPT, ST_SEQ, ST_OUT_COUNT, ST_VALUE, ST_OUT_LEN, ST_OUT_SCRIPT,
        ST_WIT_COUNT, ST_WIT_LEN, ST_WIT_DATA, ST_LOCK, ST_DONE
    } parse_st_t;

    class tx_record_checker;

        rec_t        pending_records[$];
        int unsigned mismatches;
        int unsigned records_seen;

        // shadow copy of the parser state
        parse_st_t   st;
        logic [3:0]  pos;
        logic [3:0]  vlen;
        logic [63:0] acc;
        logic [63:0] ins_left;
        logic [63:0] outs_left;
        logic [63:0] len_left;
        logic [63:0] wit_left;
        logic [63:0] entry;
        logic        segwit;
        logic        null_hash;
        logic [7:0]  held;

        // records caused by the byte being taken
        rec_t        step_rec[2];
        int          step_n;

        function new();
            mismatches   = 0;
            records_seen = 0;
            clear();
        endfunction

        function void clear();
            st        = ST_VERSION;
            pos       = 4'd0;
            vlen      = 4'd0;
            acc       = 64'd0;
            ins_left  = 64'd0;
            outs_left = 64'd0;
            len_left  = 64'd0;
            wit_left  = 64'd0;
            entry     = 64'd0;
            segwit    = 1'b0;
            null_hash = 1'b1;
            held      = 8'h00;
        endfunction

        // A third record on one byte replaces the second.
        function void put(kind_t k, logic [63:0] v, logic [63:0] ent, logic cb, logic last);
            rec_t r;
            if (step_n >= 2)
                step_n = 1;
            r.kind     = k;
            r.value    = v;
            r.entry    = ent[31:0];
            r.coinbase = cb;
            r.last     = last;
            step_rec[step_n] = r;
            step_n++;
        endfunction

        function bit take_fixed(logic [7:0] b, int n, output logic [63:0] v);
            acc = acc | (64'(b) << (8 * pos[2:0]));
            pos = pos + 4'd1;
            if (pos >= n) begin
                v   = acc;
                acc = 64'd0;
                pos = 4'd0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit take_compact(logic [7:0] b, output logic [63:0] v);
            if (vlen == 4'd0) begin
                if (b < CS_PREFIX16) begin
                    v = 64'(b);
                    return 1'b1;
                end
                vlen = (b == CS_PREFIX16) ? 4'd2 : (b == CS_PREFIX32) ? 4'd4 : 4'd8;
                pos  = 4'd0;
                acc  = 64'd0;
                return 1'b0;
            end
            acc = acc | (64'(b) << (8 * pos[2:0]));
            pos = pos + 4'd1;
            if (pos >= vlen) begin
                v    = acc;
                acc  = 64'd0;
                pos  = 4'd0;
                vlen = 4'd0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit oversize(logic [63:0] v);
            if (v > COUNT_MASK) begin
                put(KIND_TOO_LARGE, v, 64'd0, 1'b0, 1'b1);
                st = ST_DONE;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void begin_input();
            null_hash = 1'b1;
            len_left  = 64'd32;
            st        = ST_HASH;
        endfunction

        function void begin_outputs();
            ins_left = entry;
            entry    = 64'd0;
            st       = ST_OUT_COUNT;
        endfunction

        function void outputs_done();
            entry = 64'd0;
            st    = (segwit && ins_left != 64'd0) ? ST_WIT_COUNT : ST_LOCK;
        endfunction

        function void output_done();
            entry     = (entry + 64'd1) & COUNT_MASK;
            outs_left = outs_left - 64'd1;
            if (outs_left == 64'd0)
                outputs_done();
            else
                st = ST_VALUE;
        endfunction

        function void witness_input_done();
            entry    = (entry + 64'd1) & COUNT_MASK;
            ins_left = ins_left - 64'd1;
            st       = (ins_left == 64'd0) ? ST_LOCK : ST_WIT_COUNT;
        endfunction

        function void witness_item_done();
            wit_left = wit_left - 64'd1;
            if (wit_left == 64'd0)
                witness_input_done();
            else
                st = ST_WIT_LEN;
        endfunction

        function void take_in_count(logic [7:0] b);
            logic [63:0] v;
            st = ST_IN_COUNT;
            if (!take_compact(b, v) || oversize(v))
                return;
            put(KIND_IN_COUNT, v, 64'd0, 1'b0, 1'b0);
            entry    = 64'd0;
            ins_left = v;
            if (v == 64'd0)
                begin_outputs();
            else
                begin_input();
        endfunction

        function void take_out_count(logic [7:0] b);
            logic [63:0] v;
            if (!take_compact(b, v) || oversize(v))
                return;
            put(KIND_OUT_COUNT, v, 64'd0, 1'b0, 1'b0);
            outs_left = v;
            if (v == 64'd0)
                outputs_done();
            else
                st = ST_VALUE;
        endfunction

        // Advance the shadow parser by one accepted byte and queue its records.
        function void take_byte(logic [7:0] b, logic fin);
            logic [63:0] v;
            step_n = 0;
            case (st)
                ST_VERSION:
                    if (take_fixed(b, 4, v))
                    begin
                        put(KIND_VERSION, v, 64'd0, 1'b0, 1'b0);
                        st = ST_MARK;
                    end
                ST_MARK:
                    if (b == SEGWIT_MARKER && !fin)
                    begin
                        held = b;
                        st   = ST_FLAG;
                    end
                    else
                        take_in_count(b);
                ST_FLAG:
                    if (b == SEGWIT_FLAG)
                    begin
                        segwit = 1'b1;
                        put(KIND_SEGWIT, 64'd1, 64'd0, 1'b0, 1'b0);
                        st = ST_IN_COUNT;
                    end
                    else
                    begin
                        take_in_count(held);
                        if (st == ST_OUT_COUNT)
                            take_out_count(b);
                    end
                ST_IN_COUNT:
                    take_in_count(b);
                ST_HASH:
                begin
                    put(KIND_HASH_BYTE, 64'(b), entry, 1'b0, 1'b0);
                    if (b != 8'h00)
                        null_hash = 1'b0;
                    len_left = len_left - 64'd1;
                    if (len_left == 64'd0)
                        st = ST_INDEX;
                end
                ST_INDEX:
                    if (take_fixed(b, 4, v))
                    begin
                        null_hash = null_hash && (v == 64'hffff_ffff);
                        put(KIND_PREV_INDEX, v, entry, null_hash, 1'b0);
                        st = ST_IN_LEN;
                    end
                ST_IN_LEN:
                    if (take_compact(b, v) && !oversize(v))
                    begin
                        put(KIND_IN_LEN, v, entry, null_hash, 1'b0);
                        len_left = v;
                        st = (v == 64'd0) ? ST_SEQ : ST_IN_SCRIPT;
                    end
                ST_IN_SCRIPT:
                begin
                    put(KIND_IN_BYTE, 64'(b), entry, null_hash, 1'b0);
                    len_left = len_left - 64'd1;
                    if (len_left == 64'd0)
                        st = ST_SEQ;
                end
                ST_SEQ:
                    if (take_fixed(b, 4, v))
                    begin
                        put(KIND_SEQUENCE, v, entry, null_hash, 1'b0);
                        entry    = (entry + 64'd1) & COUNT_MASK;
                        ins_left = ins_left - 64'd1;
                        if (ins_left == 64'd0)
                            begin_outputs();
                        else
                            begin_input();
                    end
                ST_OUT_COUNT:
                    take_out_count(b);
                ST_VALUE:
                    if (take_fixed(b, 8, v))
                    begin
                        put(KIND_VALUE, v, entry, 1'b0, 1'b0);
                        st = ST_OUT_LEN;
                    end
                ST_OUT_LEN:
                    if (take_compact(b, v) && !oversize(v))
                    begin
                        put(KIND_OUT_LEN, v, entry, 1'b0, 1'b0);
                        len_left = v;
                        if (v == 64'd0)
                            output_done();
                        else
                            st = ST_OUT_SCRIPT;
                    end
                ST_OUT_SCRIPT:
                begin
                    put(KIND_OUT_BYTE, 64'(b), entry, 1'b0, 1'b0);
                    len_left = len_left - 64'd1;
                    if (len_left == 64'd0)
                        output_done();
                end
                ST_WIT_COUNT:
                    if (take_compact(b, v) && !oversize(v))
                    begin
                        wit_left = v;
                        if (v == 64'd0)
                            witness_input_done();
                        else
                            st = ST_WIT_LEN;
                    end
                ST_WIT_LEN:
                    if (take_compact(b, v) && !oversize(v))
                    begin
                        len_left = v;
                        if (v == 64'd0)
                            witness_item_done();
                        else
                            st = ST_WIT_DATA;
                    end
                ST_WIT_DATA:
                begin
                    len_left = len_left - 64'd1;
                    if (len_left == 64'd0)
                        witness_item_done();
                end
                ST_LOCK:
                    if (take_fixed(b, 4, v))
                    begin
                        put(KIND_LOCKTIME, v, 64'd0, 1'b0, 1'b0);
                        put(KIND_OK, 64'd0, 64'd0, 1'b0, 1'b1);
                        st = ST_DONE;
                    end
                default:
                    st = ST_DONE;
            endcase
            if (fin)
            begin
                if (st != ST_DONE)
                    put(KIND_PARSE_ERR, 64'd0, 64'd0, 1'b0, 1'b1);
                clear();
            end
            for (int i = 0; i < step_n; i++)
                pending_records = {pending_records, step_rec[i]};
        endfunction

        function void check_record(logic [3:0] kind, logic [63:0] value, logic [31:0] ent,
                                   logic cb, logic last);
            rec_t want;
            records_seen++;
            if (pending_records.size() == 0)
            begin
                $error("record with nothing pending: field_kind %0d field_value %h",
                       kind, value);
                mismatches++;
                return;
            end
            want = pending_records.pop_front();
            if (kind !== want.kind)
            begin
                $error("field_kind: expected %0d, actual %0d", want.kind, kind);
                mismatches++;
            end
            if (value !== want.value)
            begin
                $error("field_value: expected %h, actual %h", want.value, value);
                mismatches++;
            end
            if (ent !== want.entry)
            begin
                $error("entry_number: expected %0d, actual %0d", want.entry, ent);
                mismatches++;
            end
            if (cb !== want.coinbase)
            begin
                $error("is_coinbase: expected %b, actual %b", want.coinbase, cb);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("end_of_transaction: expected %b, actual %b", want.last, last);
                mismatches++;
            end
        endfunction

        function int records_due();
            return pending_records.size();
        endfunction

    endclass

endpackage

@@ sim/bitcoin_tx_stream_parser_tb.sv @@
// Testbench top: drives serialized transactions into the parser and checks every record.
`timescale 1ns / 1ps

module bitcoin_tx_stream_parser_tb;

    import bctx_pkg::*;
    import bctx_tb_pkg::*;

    localparam int RANDOM_BYTES = 1350;
    localparam int CYCLE_LIMIT  = 400000;

    // Places in a transaction where a count can be replaced by an oversized one.
    localparam int SITE_NONE      = 0;
    localparam int SITE_IN_COUNT  = 1;
    localparam int SITE_IN_LEN    = 2;
    localparam int SITE_OUT_COUNT = 3;
    localparam int SITE_OUT_LEN   = 4;
    localparam int SITE_WIT_COUNT = 5;
    localparam int SITE_WIT_LEN   = 6;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte  = 8'h00;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [3:0]  field_kind;
    logic [63:0] field_value;
    logic [31:0] entry_number;
    logic        is_coinbase;
    logic        end_of_transaction;

    tx_record_checker records;

    // Bytes of the buffer being built, sent in order with final_byte on the last.
    logic [7:0] tx_bytes[$];
    int         oversize_site = SITE_NONE;

    int burst_left    = 0;
    int bytes_sent    = 0;
    int buffers_sent  = 0;
    int cut_count     = 0;
    int oversize_hits = 0;
    int cycle_count   = 0;

    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    bitcoin_tx_stream_parser dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .data_byte          (data_byte),
        .final_byte         (final_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .field_kind         (field_kind),
        .field_value        (field_value),
        .entry_number       (entry_number),
        .is_coinbase        (is_coinbase),
        .end_of_transaction (end_of_transaction)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Receiver: switch among stall patterns at the end of each random run. Modes are
    // free flow, light random stalls, heavy random stalls, a short periodic
    // pattern and long stall runs that back the block up into in_stall.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 4);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            3: out_stall <= ((stall_tick % 5) >= 3);
            default: out_stall <= ((stall_tick % 16) < 10);
        endcase
    end

    // Sample each record at the edge where it is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            records.check_record(field_kind, field_value, entry_number, is_coinbase,
                                 end_of_transaction);
    end

    // Append one byte to the buffer being built.
    task automatic append_byte(input logic [7:0] b);
        tx_bytes = {tx_bytes, b};
    endtask

    // Append n bytes of v, least significant first.
    task automatic put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            append_byte(v[8*i +: 8]);
    endtask

    // Append a CompactSize count. Mostly canonical; sometimes use a wider
    // prefix than needed, which the parser must accept. At the chosen site,
    // put an oversized value instead (once per buffer).
    task automatic put_count(input logic [63:0] v, input int site);
        logic [63:0] big;
        int          form;
        if (site == oversize_site)
        begin
            case ($urandom_range(0, 2))
                0: big = COUNT_MASK + 64'd1;
                1: big = '1;
                default: big = {32'($urandom), 32'($urandom)} | (COUNT_MASK + 64'd1);
            endcase
            append_byte(CS_PREFIX64);
            put_le(big, 8);
            oversize_site = SITE_NONE;
            oversize_hits++;
            return;
        end
        form = $urandom_range(0, 7);
        if (v < 64'd253 && form < 5)
            append_byte(v[7:0]);
        else if (v <= 64'hffff && form < 6)
        begin
            append_byte(CS_PREFIX16);
            put_le(v, 2);
        end
        else if (v <= 64'hffff_ffff && form < 7)
        begin
            append_byte(CS_PREFIX32);
            put_le(v, 4);
        end
        else
        begin
            append_byte(CS_PREFIX64);
            put_le(v, 8);
        end
    endtask

    // Build a well-formed transaction with random content: small input and
    // output counts, short scripts, coinbase and near-coinbase inputs, and
    // per-input witness stacks when the segwit marker is present.
    task automatic build_tx();
        int   n_in;
        int   n_out;
        int   n_items;
        int   len;
        int   pick;
        int   prev_kind;
        logic segw;
        tx_bytes.delete();
        put_le(64'($urandom), 4);
        segw = 1'($urandom_range(0, 1));
        if (segw)
        begin
            append_byte(SEGWIT_MARKER);
            append_byte(SEGWIT_FLAG);
        end
        pick = $urandom_range(0, 7);
        n_in = (pick == 0) ? 0 : (pick < 5) ? 1 : (pick < 7) ? 2 : 3;
        put_count(64'(n_in), SITE_IN_COUNT);
        for (int i = 0; i < n_in; i++)
        begin
            // 0: coinbase, 1: null hash with a real index, 2: real hash with
            // the null index, else fully random
            prev_kind = $urandom_range(0, 5);
            for (int j = 0; j < 32; j++)
            begin
                if (prev_kind < 2 || $urandom_range(0, 3) == 0)
                    append_byte(8'h00);
                else
                    append_byte(8'($urandom));
            end
            if (prev_kind == 0 || prev_kind == 2)
                put_le(64'hffff_ffff, 4);
            else
                put_le(64'($urandom), 4);
            len = $urandom_range(0, 5);
            put_count(64'(len), SITE_IN_LEN);
            repeat (len) append_byte(8'($urandom));
            put_le(64'($urandom), 4);
        end
        n_out = $urandom_range(0, 3);
        put_count(64'(n_out), SITE_OUT_COUNT);
        for (int i = 0; i < n_out; i++)
        begin
            put_le({32'($urandom), 32'($urandom)}, 8);
            len = $urandom_range(0, 5);
            put_count(64'(len), SITE_OUT_LEN);
            repeat (len) append_byte(8'($urandom));
        end
        if (segw)
        begin
            for (int i = 0; i < n_in; i++)
            begin
                n_items = $urandom_range(0, 2);
                put_count(64'(n_items), SITE_WIT_COUNT);
                for (int k = 0; k < n_items; k++)
                begin
                    len = $urandom_range(0, 4);
                    put_count(64'(len), SITE_WIT_LEN);
                    repeat (len) append_byte(8'($urandom));
                end
            end
        end
        put_le(64'($urandom), 4);
    endtask

    // Offer one byte and hold it until accepted. Start a new burst, with an
    // idle gap of random length in front of it, whenever the old one runs
    // out. Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                // drive junk while idle; the block must ignore it
                in_valid   <= 1'b0;
                data_byte  <= 8'($urandom);
                final_byte <= 1'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        records.take_byte(b, fin);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_tx();
        for (int i = 0; i < tx_bytes.size(); i++)
            send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
        buffers_sent++;
    endtask

    // Drop valid and hold off until every pending record has come out.
    task automatic pause_for_drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (records.records_due() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int sel;
        int cut;
        int first_random;
        records = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A lone final byte: the version is cut short.
        tx_bytes = '{8'h5a};
        send_tx();
        // All-ones version, a zero after it that turns out to be an input
        // count of zero, zero outputs, all-ones locktime; the last byte gives
        // locktime and ok together.
        tx_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00,
                     8'hff, 8'hff, 8'hff, 8'hff};
        send_tx();
        // All-zero version, then a zero on the final byte: taken as the
        // input count, followed by a parse error.
        tx_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_tx();
        // Held zero, then a final byte that is not the flag: the parse
        // error replaces its output count record.
        tx_bytes = '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hfc};
        send_tx();
        pause_for_drain();

        first_random = bytes_sent;
        while (bytes_sent - first_random < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 15);
            oversize_site = SITE_NONE;
            if (sel < 2)
            begin
                // noise: a short run of random bytes
                tx_bytes.delete();
                repeat ($urandom_range(1, 16)) append_byte(8'($urandom));
            end
            else if (sel < 4)
            begin
                // version, a zero, and maybe one more byte, ending on the last
                tx_bytes.delete();
                put_le(64'($urandom), 4);
                append_byte(SEGWIT_MARKER);
                if ($urandom_range(0, 1) == 1)
                    append_byte(8'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    oversize_site = $urandom_range(SITE_IN_COUNT, SITE_WIT_LEN);
                build_tx();
                if (sel < 7)
                begin
                    // cut short at a random point
                    cut = $urandom_range(1, tx_bytes.size() - 1);
                    tx_bytes = tx_bytes[0:cut-1];
                    cut_count++;
                end
                else if (sel < 10)
                begin
                    // trailing bytes after the record that closes the transaction
                    repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
                end
            end
            send_tx();
            if (buffers_sent % 6 == 0)
                pause_for_drain();
        end

        in_valid <= 1'b0;
        while (records.records_due() != 0)
            @(posedge clk);
        // catch any stray record after the last expected one
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d buffers: %0d cut short, %0d with an oversized count.",
                 bytes_sent, buffers_sent, cut_count, oversize_hits);
        $display("Checked %0d records under varied stalls, %0d mismatches.",
                 records.records_seen, records.mismatches);
        if (records.mismatches == 0)
            $display("bitcoin_tx_stream_parser_tb: done, clean");
        else
            $display("bitcoin_tx_stream_parser_tb: done, errors");
        $finish;
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("timed out after %0d cycles with %0d records pending",
                 cycle_count, records.records_due());
        $display("bitcoin_tx_stream_parser_tb: done, errors");
        $finish;
    end

endmodule
